### rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

	localparam int DEFAULT_CAPACITY = 256;
	localparam int DATA_W           = 32;
	localparam int POS_W            = 16;
	localparam int OUT_POS_W        = 9;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_READ   = 2'd2,
		FN_SEARCH = 2'd3
	} func_e_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_REJECT = 2'd1,
		ST_FULL   = 2'd2
	} status_e_t;

	typedef struct packed {
		func_e_t                    func;
		logic [POS_W-1:0]           position;
		logic signed [DATA_W-1:0]   value_in;
	} req_t;

	typedef struct packed {
		status_e_t                  status;
		logic signed [DATA_W-1:0]   value_out;
		logic [OUT_POS_W-1:0]       found_position;
		logic [OUT_POS_W-1:0]       entry_count;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/ple_stream_if.sv
`default_nettype none

interface ple_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/positional_list_engine.sv
// Channel  Role    Payload                                          Item moves when
// -------  ------  -----------------------------------------------  ---------------
// req      sink    func, position, value_in                         valid & ready
// rsp      source  status, value_out, found_position, entry_count   valid & ready
//
// One item is worked at a time; each one gives exactly one result item.
// Reject and full results come straight back. An insert at the tail writes at once;
// any other moves each entry from the position to the tail back first. A delete
// reads each entry from the position to the tail; a search compares at most the
// entry count of entries. The memory does one read and one write per cycle.
// Reset clears the entry count and the control state; memory contents are never cleared.
// The result register lets the next item be taken while rsp is stalled.
`default_nettype none

module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ple_stream_if.sink   req,
	ple_stream_if.source rsp
);
	import ple_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic              res_valid;
	logic              res_ready;
	rsp_t              res_data;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_data_q;

	ple_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_data  (req.payload),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ple_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer hands over its result whenever the output slot is free or draining
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_data_q <= res_data;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

endmodule

`default_nettype wire

### rtl/ple_mem.sv
`default_nettype none

module ple_mem #(
	parameter int DEPTH = ple_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [ple_pkg::DATA_W-1:0] wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [ple_pkg::DATA_W-1:0] rdata
);
	import ple_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/ple_seq.sv
`default_nettype none

module ple_seq #(
	parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire ple_pkg::req_t                 req_data,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output ple_pkg::rsp_t                      res_data,
	output logic                               mem_we,
	output logic [$clog2(CAPACITY)-1:0]        mem_waddr,
	output logic [ple_pkg::DATA_W-1:0]         mem_wdata,
	output logic [$clog2(CAPACITY)-1:0]        mem_raddr,
	input  wire logic [ple_pkg::DATA_W-1:0]    mem_rdata
);
	import ple_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b0000000001,
		S_INS_SHIFT = 10'b0000000010,
		S_INS_DRAIN = 10'b0000000100,
		S_INS_PUT   = 10'b0000001000,
		S_DEL_SCAN  = 10'b0000010000,
		S_DEL_DRAIN = 10'b0000100000,
		S_RD_ISSUE  = 10'b0001000000,
		S_RD_WAIT   = 10'b0010000000,
		S_SRCH      = 10'b0100000000,
		S_FINISH    = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     lo_q;
	logic [AW-1:0]     hi_q;
	logic [AW-1:0]     prev_q;
	logic              pend_q;
	logic [DATA_W-1:0] val_q;
	status_e_t         status_q;
	logic [DATA_W-1:0] vout_q;
	logic [CW-1:0]     found_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     prevpos_q;
	logic              side_q;     // 0 front, 1 back
	logic              issuing_q;

	logic [31:0] pos32;
	logic [31:0] cnt32;
	logic [31:0] found32;
	logic [31:0] ins_idx32;
	logic [31:0] del_idx32;
	logic [CW-1:0] srch_pos;

	assign pos32 = 32'(req_data.position);
	assign cnt32 = 32'(count_q);
	assign found32 = 32'(found_q);
	assign srch_pos = side_q ? j_q : i_q;

	always_comb begin
		priority if (cnt32 == 32'd0 || pos32 == 32'd1) begin
			ins_idx32 = 32'd0;
		end else if (pos32 >= cnt32) begin
			ins_idx32 = cnt32;
		end else begin
			ins_idx32 = pos32 - 32'd1;
		end
	end

	always_comb begin
		priority if (pos32 == 32'd1) begin
			del_idx32 = 32'd0;
		end else if (pos32 >= cnt32) begin
			del_idx32 = cnt32 - 32'd1;
		end else begin
			del_idx32 = pos32 - 32'd1;
		end
	end

	// memory port: one write, one registered read per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = prev_q;
		mem_wdata = mem_rdata;
		mem_raddr = ptr_q;
		unique case (state_q)
			S_INS_SHIFT, S_INS_DRAIN: begin
				mem_we    = pend_q;
				mem_waddr = prev_q + AW'(1);
			end
			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = val_q;
			end
			S_DEL_SCAN, S_DEL_DRAIN: begin
				// first read is the removed entry, later ones move forward
				mem_we    = pend_q && (prev_q != lo_q);
				mem_waddr = prev_q - AW'(1);
			end
			S_RD_ISSUE: begin
				mem_raddr = lo_q;
			end
			S_SRCH: begin
				mem_raddr = AW'(srch_pos - CW'(1));
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);

	always_comb begin
		res_data.status         = status_q;
		res_data.value_out      = vout_q;
		res_data.found_position = found32[OUT_POS_W-1:0];
		res_data.entry_count    = cnt32[OUT_POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			pend_q    <= 1'b0;
			issuing_q <= 1'b0;
			side_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						val_q    <= req_data.value_in;
						pend_q   <= 1'b0;
						vout_q   <= '0;
						found_q  <= '0;
						status_q <= ST_DONE;
						unique case (req_data.func)
							FN_INSERT: begin
								priority if (pos32 == 32'd0) begin
									status_q <= ST_REJECT;
									state_q  <= S_FINISH;
								end else if (cnt32 >= 32'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_FINISH;
								end else begin
									lo_q  <= AW'(ins_idx32);
									ptr_q <= AW'(cnt32 - 32'd1);
									state_q <= (ins_idx32 == cnt32) ? S_INS_PUT : S_INS_SHIFT;
								end
							end
							FN_DELETE: begin
								if (cnt32 == 32'd0 || pos32 == 32'd0) begin
									status_q <= ST_REJECT;
									state_q  <= S_FINISH;
								end else begin
									lo_q    <= AW'(del_idx32);
									ptr_q   <= AW'(del_idx32);
									hi_q    <= AW'(cnt32 - 32'd1);
									state_q <= S_DEL_SCAN;
								end
							end
							FN_READ: begin
								if (cnt32 == 32'd0 || pos32 == 32'd0 || pos32 > cnt32) begin
									status_q <= ST_REJECT;
									state_q  <= S_FINISH;
								end else begin
									lo_q    <= AW'(pos32 - 32'd1);
									state_q <= S_RD_ISSUE;
								end
							end
							FN_SEARCH: begin
								if (cnt32 == 32'd0) begin
									status_q <= ST_REJECT;
									state_q  <= S_FINISH;
								end else begin
									i_q       <= CW'(1);
									j_q       <= count_q;
									side_q    <= 1'b0;
									issuing_q <= 1'b1;
									state_q   <= S_SRCH;
								end
							end
						endcase
					end
				end
				S_INS_SHIFT: begin
					prev_q <= ptr_q;
					pend_q <= 1'b1;
					if (ptr_q == lo_q) begin
						state_q <= S_INS_DRAIN;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				S_INS_DRAIN: begin
					pend_q  <= 1'b0;
					state_q <= S_INS_PUT;
				end
				S_INS_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_DEL_SCAN: begin
					if (pend_q && prev_q == lo_q) begin
						vout_q <= mem_rdata;
					end
					prev_q <= ptr_q;
					pend_q <= 1'b1;
					if (ptr_q == hi_q) begin
						state_q <= S_DEL_DRAIN;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_DEL_DRAIN: begin
					if (prev_q == lo_q) begin
						vout_q <= mem_rdata;
					end
					pend_q  <= 1'b0;
					count_q <= count_q - CW'(1);
					state_q <= S_FINISH;
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					vout_q  <= mem_rdata;
					state_q <= S_FINISH;
				end
				S_SRCH: begin
					pend_q <= issuing_q;
					if (issuing_q) begin
						prevpos_q <= srch_pos;
						if (!side_q) begin
							if (i_q < j_q) begin
								side_q <= 1'b1;
							end else begin
								issuing_q <= 1'b0;
							end
						end else begin
							i_q <= i_q + CW'(1);
							j_q <= j_q - CW'(1);
							if ((i_q + CW'(1)) < j_q) begin
								side_q <= 1'b0;
							end else begin
								issuing_q <= 1'b0;
							end
						end
					end
					// compares retire in issue order, so the first hit wins
					if (pend_q && mem_rdata == val_q) begin
						found_q   <= prevpos_q;
						issuing_q <= 1'b0;
						pend_q    <= 1'b0;
						state_q   <= S_FINISH;
					end else if (pend_q && !issuing_q) begin
						status_q <= ST_REJECT;
						pend_q   <= 1'b0;
						state_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/ple_check.sv
`default_nettype none

module ple_check #(
	parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] value_out,
	input wire logic [8:0]  found_position,
	input wire logic [8:0]  entry_count
);
	import ple_pkg::*;

	// one item in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ple: second item taken while one is in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(value_out)
			&& $stable(found_position) && $stable(entry_count))
		else $error("ple: stalled result changed");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> value_out == 32'd0 && found_position == 9'd0
			&& (CAPACITY > 511 || 32'(entry_count) == CAPACITY))
		else $error("ple: full status with bad fields");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found_position != 9'd0 |-> status == ST_DONE && value_out == 32'd0)
		else $error("ple: search hit with bad fields");

endmodule

bind positional_list_engine ple_check #(
	.CAPACITY(CAPACITY)
) u_ple_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.payload.status),
	.value_out      (rsp.payload.value_out),
	.found_position (rsp.payload.found_position),
	.entry_count    (rsp.payload.entry_count)
);

`default_nettype wire
